FILE: src/cclb_pkg.sv
// shared types, constants and calendar helpers for the calendar clock core
// no dependencies

package cclb_pkg;

   localparam int TICKS_PER_SECOND_DEF = 4;

   localparam logic [13:0] MAX_LOOKBACK = 14'd11819;
   localparam logic [13:0] MIN_PER_DAY  = 14'd1440;
   // floor(x / 60) == (x * RECIP_60) >> RECIP_SHIFT for x below one day of minutes
   localparam logic [11:0] RECIP_60     = 12'd2185;
   localparam int          RECIP_SHIFT  = 17;

   localparam logic [5:0] SEC_PER_MIN  = 6'd60;
   localparam logic [5:0] MIN_PER_HOUR = 6'd60;
   localparam logic [4:0] HOUR_PER_DAY = 5'd24;
   localparam logic [3:0] MONTHS       = 4'd12;

   localparam logic [4:0] MONTH_DAYS [13] = '{
      5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
      5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
   };

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic tick;
      logic load;
      logic walk;
      logic mult;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic out_valid;
      logic rem_ge_day;
   } status_type;

   typedef struct packed {
      logic [4:0] day;
      logic [3:0] mon;
      logic [7:0] yr;
   } date_type;

   function automatic logic [4:0] days_in(input logic [3:0] month, input logic [7:0] year);
      logic [4:0] d;
      if (month < 4'd1 || month > MONTHS) begin
         d = 5'd31;
      end else if (month == 4'd2) begin
         d = (year[1:0] == 2'b00) ? 5'd29 : 5'd28;
      end else begin
         d = MONTH_DAYS[month];
      end
      return d;
   endfunction

   function automatic date_type step_back(input date_type cur);
      date_type nxt;
      nxt = cur;
      if (cur.day <= 5'd1) begin
         if (cur.mon <= 4'd1) begin
            nxt.mon = MONTHS;
            nxt.yr  = cur.yr - 8'd1;
         end else begin
            nxt.mon = cur.mon - 4'd1;
         end
         nxt.day = days_in(nxt.mon, nxt.yr);
      end else begin
         nxt.day = cur.day - 5'd1;
      end
      return nxt;
   endfunction

endpackage

FILE: src/cclb_req_if.sv
// request channel of the calendar clock core: tick or lookback query
// no dependencies

interface cclb_req_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [13:0] minutes_ago;

   modport source (output valid, output kind, output minutes_ago, input ready);
   modport sink   (input valid, input kind, input minutes_ago, output ready);
endinterface

FILE: src/cclb_rsp_if.sv
// response channel of the calendar clock core: one calendar time per request
// no dependencies

interface cclb_rsp_if;
   logic       valid;
   logic       ready;
   logic       from_query;
   logic [5:0] second_out;
   logic [5:0] minute_out;
   logic [4:0] hour_out;
   logic [3:0] hour_twelve;
   logic       is_pm;
   logic [4:0] day_out;
   logic [3:0] month_out;
   logic [7:0] year_out;

   modport source (output valid, output from_query, output second_out, output minute_out,
                   output hour_out, output hour_twelve, output is_pm, output day_out,
                   output month_out, output year_out, input ready);
   modport sink   (input valid, input from_query, input second_out, input minute_out,
                   input hour_out, input hour_twelve, input is_pm, input day_out,
                   input month_out, input year_out, output ready);
endinterface

FILE: src/cclb_ctrl.sv
// controller of the calendar clock core: sequences tick updates and query walks
// depends on cclb_pkg

module cclb_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_kind,
   output logic                 req_ready,
   input  logic                 rsp_ready,
   input  cclb_pkg::status_type status,
   output cclb_pkg::cmd_type    cmd
);

   cclb_pkg::state_type state_ff, state_in;
   logic accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cclb_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_ready  = 1'b0;
      accept     = 1'b0;
      case (state_ff)
         cclb_pkg::ST_IDLE: begin
            // the result slot must be free by the time this beat's result lands
            req_ready = !status.out_valid || rsp_ready;
            accept    = req_valid && req_ready;
            cmd.tick  = accept && !req_kind;
            cmd.load  = accept && req_kind;
            if (accept && req_kind) begin
               state_in = cclb_pkg::ST_WALK;
            end
         end
         cclb_pkg::ST_WALK: begin
            // one whole day back per cycle, then split what is left into hours
            if (status.rem_ge_day) begin
               cmd.walk = 1'b1;
            end else begin
               cmd.mult = 1'b1;
               state_in = cclb_pkg::ST_FINISH;
            end
         end
         cclb_pkg::ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = cclb_pkg::ST_IDLE;
         end
         default: begin
            state_in = cclb_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

FILE: src/cclb_dp.sv
// datapath of the calendar clock core: running clock, lookback registers, result register
// depends on cclb_pkg

module cclb_dp #(
   parameter int TICKS_PER_SECOND = cclb_pkg::TICKS_PER_SECOND_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cclb_pkg::cmd_type    cmd,
   output cclb_pkg::status_type status,
   input  logic [13:0]          req_minutes_ago,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output logic                 rsp_from_query,
   output logic [5:0]           rsp_second_out,
   output logic [5:0]           rsp_minute_out,
   output logic [4:0]           rsp_hour_out,
   output logic [3:0]           rsp_hour_twelve,
   output logic                 rsp_is_pm,
   output logic [4:0]           rsp_day_out,
   output logic [3:0]           rsp_month_out,
   output logic [7:0]           rsp_year_out
);

   localparam int PW = (TICKS_PER_SECOND > 1) ? $clog2(TICKS_PER_SECOND) : 1;
   localparam logic [PW-1:0] PHASE_LAST = PW'(TICKS_PER_SECOND - 1);

   // running clock
   logic [PW-1:0] phase_ff, phase_in;
   logic [5:0]    sec_ff, sec_in;
   logic [5:0]    min_ff, min_in;
   logic [4:0]    hour_ff, hour_in;
   logic [4:0]    day_ff, day_in;
   logic [3:0]    mon_ff, mon_in;
   logic [7:0]    yr_ff, yr_in;

   // lookback work registers
   logic [13:0]        rem_ff, rem_in;
   logic [4:0]         quo_ff, quo_in;
   cclb_pkg::date_type date_ff, date_in;

   // result register
   logic       valid_ff, valid_in;
   logic       q_ff, q_in;
   logic [5:0] osec_ff, osec_in;
   logic [5:0] omin_ff, omin_in;
   logic [4:0] ohour_ff, ohour_in;
   logic [4:0] oday_ff, oday_in;
   logic [3:0] omon_ff, omon_in;
   logic [7:0] oyr_ff, oyr_in;

   logic [13:0]        ago_sat;
   logic [22:0]        product;
   logic [10:0]        sixty_q;
   logic [5:0]         min_part;
   logic               borrow;
   logic [5:0]         hour_need;
   cclb_pkg::date_type date_back;
   logic [5:0]         day_inc;
   logic [3:0]         mon_inc;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         sec_ff   <= '0;
         min_ff   <= '0;
         hour_ff  <= '0;
         day_ff   <= 5'd1;
         mon_ff   <= 4'd1;
         yr_ff    <= '0;
         valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         sec_ff   <= sec_in;
         min_ff   <= min_in;
         hour_ff  <= hour_in;
         day_ff   <= day_in;
         mon_ff   <= mon_in;
         yr_ff    <= yr_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      date_ff  <= date_in;
      q_ff     <= q_in;
      osec_ff  <= osec_in;
      omin_ff  <= omin_in;
      ohour_ff <= ohour_in;
      oday_ff  <= oday_in;
      omon_ff  <= omon_in;
      oyr_ff   <= oyr_in;
   end

   // clock advance on a tick beat, carries ripple up to the year
   always_comb begin
      phase_in = phase_ff;
      sec_in   = sec_ff;
      min_in   = min_ff;
      hour_in  = hour_ff;
      day_in   = day_ff;
      mon_in   = mon_ff;
      yr_in    = yr_ff;
      day_inc  = {1'b0, day_ff} + 6'd1;
      mon_inc  = mon_ff + 4'd1;
      if (cmd.tick) begin
         if (phase_ff != PHASE_LAST) begin
            phase_in = phase_ff + PW'(1);
         end else begin
            phase_in = '0;
            if (sec_ff + 6'd1 < cclb_pkg::SEC_PER_MIN) begin
               sec_in = sec_ff + 6'd1;
            end else begin
               sec_in = '0;
               if (min_ff + 6'd1 < cclb_pkg::MIN_PER_HOUR) begin
                  min_in = min_ff + 6'd1;
               end else begin
                  min_in = '0;
                  if (hour_ff + 5'd1 < cclb_pkg::HOUR_PER_DAY) begin
                     hour_in = hour_ff + 5'd1;
                  end else begin
                     hour_in = '0;
                     if (day_inc <= {1'b0, cclb_pkg::days_in(mon_ff, yr_ff)}) begin
                        day_in = day_inc[4:0];
                     end else begin
                        day_in = 5'd1;
                        if (mon_inc <= cclb_pkg::MONTHS) begin
                           mon_in = mon_inc;
                        end else begin
                           mon_in = 4'd1;
                           yr_in  = yr_ff + 8'd1;
                        end
                     end
                  end
               end
            end
         end
      end
   end

   // lookback: whole days first, then hours and minutes with borrow
   always_comb begin
      ago_sat   = (req_minutes_ago > cclb_pkg::MAX_LOOKBACK) ? cclb_pkg::MAX_LOOKBACK
                                                             : req_minutes_ago;
      product   = 23'(rem_ff[10:0]) * 23'(cclb_pkg::RECIP_60);
      sixty_q   = {quo_ff, 6'd0} - {4'd0, quo_ff, 2'd0};
      min_part  = 6'(rem_ff[10:0] - sixty_q);
      borrow    = min_ff < min_part;
      hour_need = {1'b0, quo_ff} + {5'd0, borrow};
      date_back = cclb_pkg::step_back(date_ff);

      rem_in  = rem_ff;
      quo_in  = quo_ff;
      date_in = date_ff;
      if (cmd.load) begin
         rem_in  = ago_sat;
         date_in = '{day: day_ff, mon: mon_ff, yr: yr_ff};
      end else if (cmd.walk) begin
         rem_in  = rem_ff - cclb_pkg::MIN_PER_DAY;
         date_in = date_back;
      end
      if (cmd.mult) begin
         quo_in = product[cclb_pkg::RECIP_SHIFT +: 5];
      end
   end

   // result register
   always_comb begin
      valid_in = valid_ff && !rsp_ready;
      q_in     = q_ff;
      osec_in  = osec_ff;
      omin_in  = omin_ff;
      ohour_in = ohour_ff;
      oday_in  = oday_ff;
      omon_in  = omon_ff;
      oyr_in   = oyr_ff;
      if (cmd.tick) begin
         valid_in = 1'b1;
         q_in     = 1'b0;
         osec_in  = sec_in;
         omin_in  = min_in;
         ohour_in = hour_in;
         oday_in  = day_in;
         omon_in  = mon_in;
         oyr_in   = yr_in;
      end else if (cmd.finish) begin
         valid_in = 1'b1;
         q_in     = 1'b1;
         osec_in  = '0;
         omin_in  = borrow ? (min_ff + cclb_pkg::MIN_PER_HOUR - min_part) : (min_ff - min_part);
         if ({1'b0, hour_ff} >= hour_need) begin
            ohour_in = 5'({1'b0, hour_ff} - hour_need);
            oday_in  = date_ff.day;
            omon_in  = date_ff.mon;
            oyr_in   = date_ff.yr;
         end else begin
            ohour_in = 5'({1'b0, hour_ff} + {1'b0, cclb_pkg::HOUR_PER_DAY} - hour_need);
            oday_in  = date_back.day;
            omon_in  = date_back.mon;
            oyr_in   = date_back.yr;
         end
      end
   end

   assign status.out_valid  = valid_ff;
   assign status.rem_ge_day = rem_ff >= cclb_pkg::MIN_PER_DAY;

   assign rsp_valid       = valid_ff;
   assign rsp_from_query  = q_ff;
   assign rsp_second_out  = osec_ff;
   assign rsp_minute_out  = omin_ff;
   assign rsp_hour_out    = ohour_ff;
   assign rsp_is_pm       = ohour_ff >= 5'd12;
   assign rsp_hour_twelve = (ohour_ff == 5'd0) ? 4'd12
                          : (ohour_ff > 5'd12) ? 4'(ohour_ff - 5'd12) : ohour_ff[3:0];
   assign rsp_day_out     = oday_ff;
   assign rsp_month_out   = omon_ff;
   assign rsp_year_out    = oyr_ff;

endmodule

FILE: src/calendar_clock_with_lookback_core.sv
// top level of the calendar clock core: controller plus datapath on two valid/ready channels
// depends on cclb_pkg, cclb_req_if, cclb_rsp_if, cclb_ctrl, cclb_dp

// Calendar clock driven by tick beats (kind 0), each one 1/TICKS_PER_SECOND of a second;
// every tick returns the time after it. A query beat (kind 1) returns the date and time
// minutes_ago minutes back (capped at 11819), with seconds shown as 0. A query walks back
// d = floor(minutes_ago / 1440) whole days, at most 8: the controller steps the date back
// one whole day per cycle, then the multiply step splits the leftover minutes into hours
// through a reciprocal multiply and the finish step applies the borrows and writes the
// result. One beat is worked at a time; a new beat is taken in the cycle its predecessor's
// result is taken or later, and the result register lets a tick beat be accepted in the
// same cycle the previous result leaves.

module calendar_clock_with_lookback_core #(
   parameter int TICKS_PER_SECOND = cclb_pkg::TICKS_PER_SECOND_DEF
) (
   input logic         clock,
   input logic         reset,
   cclb_req_if.sink    req_chan,
   cclb_rsp_if.source  rsp_chan
);

   cclb_pkg::cmd_type    cmd;
   cclb_pkg::status_type status;

   cclb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_kind  (req_chan.kind),
      .req_ready (req_chan.ready),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   cclb_dp #(
      .TICKS_PER_SECOND (TICKS_PER_SECOND)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_minutes_ago (req_chan.minutes_ago),
      .rsp_ready       (rsp_chan.ready),
      .rsp_valid       (rsp_chan.valid),
      .rsp_from_query  (rsp_chan.from_query),
      .rsp_second_out  (rsp_chan.second_out),
      .rsp_minute_out  (rsp_chan.minute_out),
      .rsp_hour_out    (rsp_chan.hour_out),
      .rsp_hour_twelve (rsp_chan.hour_twelve),
      .rsp_is_pm       (rsp_chan.is_pm),
      .rsp_day_out     (rsp_chan.day_out),
      .rsp_month_out   (rsp_chan.month_out),
      .rsp_year_out    (rsp_chan.year_out)
   );

endmodule

FILE: bench/testbench.sv
// self-checking bench for calendar_clock_with_lookback_core: tick and lookback beats,
// predicted in-bench and compared field by field against every response beat
// depends on cclb_pkg, cclb_req_if, cclb_rsp_if and the core

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic KIND_TICK  = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   localparam int RANDOM_BEATS  = 900;
   localparam int CYCLE_LIMIT   = 200_000;
   localparam int DRAIN_CYCLES  = 20;
   localparam int REPORT_LIMIT  = 10;

   typedef struct packed {
      logic        kind;
      logic [13:0] minutes_ago;
   } beat_type;

   typedef struct packed {
      logic       from_query;
      logic [5:0] second;
      logic [5:0] minute;
      logic [4:0] hour;
      logic [3:0] hour12;
      logic       pm;
      logic [4:0] day;
      logic [3:0] month;
      logic [7:0] year;
   } cal_time_type;

   logic clock;
   logic reset;

   cclb_req_if req_chan ();
   cclb_rsp_if rsp_chan ();

   calendar_clock_with_lookback_core i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   beat_type     pending_beats[$];
   cal_time_type expected_times[$];

   // calendar state tracked by the bench
   int unsigned tick_phase;
   logic [5:0]  cur_sec;
   logic [5:0]  cur_min;
   logic [4:0]  cur_hour;
   logic [4:0]  cur_day;
   logic [3:0]  cur_month;
   logic [7:0]  cur_year;

   int unsigned cycle_count;
   int unsigned popped_beats;
   int unsigned calm_from;
   int unsigned error_count;
   int unsigned ticks_checked;
   int unsigned queries_checked;
   int unsigned capped_queries;
   int          gap_left;
   int          stall_left;
   bit          calm;
   bit          lively_req;
   bit          lively_rsp;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [4:0] month_length(input logic [3:0] mon, input logic [7:0] yr);
      if (mon < 4'd1 || mon > 4'd12) begin
         return 5'd31;
      end
      if (mon == 4'd2) begin
         return (yr[1:0] == 2'b00) ? 5'd29 : 5'd28;
      end
      case (mon)
         4'd4, 4'd6, 4'd9, 4'd11: return 5'd30;
         default: return 5'd31;
      endcase
   endfunction

   function automatic cal_time_type pack_time(input logic q, input logic [5:0] s,
                                              input logic [5:0] m, input logic [4:0] h,
                                              input logic [4:0] d, input logic [3:0] mo,
                                              input logic [7:0] y);
      cal_time_type t;
      t.from_query = q;
      t.second     = s;
      t.minute     = m;
      t.hour       = h;
      t.hour12     = (h == 5'd0 || h == 5'd12) ? 4'd12 : 4'(h % 5'd12);
      t.pm         = (h >= 5'd12);
      t.day        = d;
      t.month      = mo;
      t.year       = y;
      return t;
   endfunction

   task automatic step_day_back(inout logic [4:0] d, inout logic [3:0] mo,
                                inout logic [7:0] y);
      if (d <= 5'd1) begin
         if (mo <= 4'd1) begin
            mo = 4'd12;
            y  = y - 8'd1;
         end else begin
            mo = mo - 4'd1;
         end
         d = month_length(mo, y);
      end else begin
         d = d - 5'd1;
      end
   endtask

   task automatic tick_clock(output cal_time_type t);
      tick_phase++;
      if (tick_phase >= cclb_pkg::TICKS_PER_SECOND_DEF) begin
         tick_phase = 0;
         if (cur_sec == 6'd59) begin
            cur_sec = 6'd0;
            if (cur_min == 6'd59) begin
               cur_min = 6'd0;
               if (cur_hour == 5'd23) begin
                  cur_hour = 5'd0;
                  if (cur_day >= month_length(cur_month, cur_year)) begin
                     cur_day = 5'd1;
                     if (cur_month >= 4'd12) begin
                        cur_month = 4'd1;
                        cur_year  = cur_year + 8'd1;
                     end else begin
                        cur_month = cur_month + 4'd1;
                     end
                  end else begin
                     cur_day = cur_day + 5'd1;
                  end
               end else begin
                  cur_hour = cur_hour + 5'd1;
               end
            end else begin
               cur_min = cur_min + 6'd1;
            end
         end else begin
            cur_sec = cur_sec + 6'd1;
         end
      end
      t = pack_time(1'b0, cur_sec, cur_min, cur_hour, cur_day, cur_month, cur_year);
   endtask

   task automatic look_back(input logic [13:0] ago_in, output cal_time_type t);
      int         ago;
      int         m;
      int         h;
      int         whole_days;
      logic [4:0] d;
      logic [3:0] mo;
      logic [7:0] y;
      ago = (ago_in > cclb_pkg::MAX_LOOKBACK) ? int'(cclb_pkg::MAX_LOOKBACK) : int'(ago_in);
      d   = cur_day;
      mo  = cur_month;
      y   = cur_year;
      m   = int'(cur_min) - ago % 60;
      h   = int'(cur_hour);
      // minute borrow comes out of the hour before the hour count is taken
      if (m < 0) begin
         m += 60;
         h -= 1;
      end
      h -= (ago / 60) % 24;
      if (h < 0) begin
         h += 24;
         step_day_back(d, mo, y);
      end
      for (whole_days = ago / 1440; whole_days > 0; whole_days--) begin
         step_day_back(d, mo, y);
      end
      t = pack_time(1'b1, 6'd0, 6'(m), 5'(h), d, mo, y);
   endtask

   task automatic predict_beat(input logic kind, input logic [13:0] ago);
      cal_time_type t;
      if (kind == KIND_TICK) begin
         tick_clock(t);
      end else begin
         if (ago > cclb_pkg::MAX_LOOKBACK) begin
            capped_queries++;
         end
         look_back(ago, t);
      end
      expected_times.push_back(t);
   endtask

   task automatic check_result();
      cal_time_type got;
      cal_time_type want;
      string        diff;
      got.from_query = rsp_chan.from_query;
      got.second     = rsp_chan.second_out;
      got.minute     = rsp_chan.minute_out;
      got.hour       = rsp_chan.hour_out;
      got.hour12     = rsp_chan.hour_twelve;
      got.pm         = rsp_chan.is_pm;
      got.day        = rsp_chan.day_out;
      got.month      = rsp_chan.month_out;
      got.year       = rsp_chan.year_out;
      if (expected_times.size() == 0) begin
         error_count++;
         if (error_count <= REPORT_LIMIT) begin
            $display("unexpected response beat %p at cycle %0d", got, cycle_count);
         end
         return;
      end
      want = expected_times.pop_front();
      if (want.from_query) begin
         queries_checked++;
      end else begin
         ticks_checked++;
      end
      diff = "";
      if (got.from_query !== want.from_query) diff = {diff, " from_query"};
      if (got.second !== want.second)         diff = {diff, " second_out"};
      if (got.minute !== want.minute)         diff = {diff, " minute_out"};
      if (got.hour !== want.hour)             diff = {diff, " hour_out"};
      if (got.hour12 !== want.hour12)         diff = {diff, " hour_twelve"};
      if (got.pm !== want.pm)                 diff = {diff, " is_pm"};
      if (got.day !== want.day)               diff = {diff, " day_out"};
      if (got.month !== want.month)           diff = {diff, " month_out"};
      if (got.year !== want.year)             diff = {diff, " year_out"};
      if (diff != "") begin
         error_count++;
         if (error_count <= REPORT_LIMIT) begin
            $display("mismatch at cycle %0d in%s", cycle_count, diff);
            $display("   expected %p", want);
            $display("   actual   %p", got);
         end
      end
   endtask

   task automatic add_beat(input logic kind, input logic [13:0] ago);
      beat_type b;
      b.kind        = kind;
      b.minutes_ago = ago;
      pending_beats.push_back(b);
   endtask

   function automatic logic [13:0] random_lookback();
      case ($urandom_range(0, 9))
         0: return 14'($urandom_range(11820, 16383));
         1: return 14'(1440 * $urandom_range(0, 8) + $urandom_range(0, 2) - 1);
         2: return 14'(60 * $urandom_range(1, 196) - $urandom_range(0, 1));
         default: return 14'($urandom_range(0, 11819));
      endcase
   endfunction

   // cycle count, timeout and the on/off pattern of random idling
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count % 97 == 0) begin
         lively_req <= ($urandom_range(0, 3) != 0);
         lively_rsp <= ($urandom_range(0, 3) != 0);
      end
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, expected_times.size());
         $display("calendar_clock_with_lookback_core regression: fail");
         $finish;
      end
   end

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            predict_beat(req_chan.kind, req_chan.minutes_ago);
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_chan.valid <= 1'b0;
            end else if (pending_beats.size() == 0) begin
               req_chan.valid <= 1'b0;
            end else if (!calm && lively_req && $urandom_range(0, 4) == 0) begin
               gap_left = $urandom_range(0, 2);
               req_chan.valid <= 1'b0;
            end else begin
               req_chan.valid       <= 1'b1;
               req_chan.kind        <= pending_beats[0].kind;
               req_chan.minutes_ago <= pending_beats[0].minutes_ago;
               void'(pending_beats.pop_front());
               popped_beats++;
               calm <= (popped_beats >= calm_from);
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            check_result();
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else if (!calm && lively_rsp && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 2);
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   initial begin : stimulus
      int unsigned n;
      int unsigned k;
      reset                = 1'b1;
      req_chan.valid       = 1'b0;
      req_chan.kind        = KIND_TICK;
      req_chan.minutes_ago = 14'd0;
      rsp_chan.ready       = 1'b0;
      tick_phase           = 0;
      cur_sec              = 6'd0;
      cur_min              = 6'd0;
      cur_hour             = 5'd0;
      cur_day              = 5'd1;
      cur_month            = 4'd1;
      cur_year             = 8'd0;
      calm_from            = 32'hffff_ffff;
      lively_req           = 1'b1;
      lively_rsp           = 1'b1;

      // directed: field extremes, borrows at the hour and day edges, the cap, year wrap back
      add_beat(KIND_TICK, 14'd0);
      add_beat(KIND_TICK, 14'h3fff);
      add_beat(KIND_QUERY, 14'd0);
      add_beat(KIND_QUERY, 14'd1);
      add_beat(KIND_QUERY, 14'd59);
      add_beat(KIND_QUERY, 14'd60);
      add_beat(KIND_QUERY, 14'd61);
      add_beat(KIND_QUERY, 14'd719);
      add_beat(KIND_QUERY, 14'd720);
      add_beat(KIND_QUERY, 14'd1439);
      add_beat(KIND_QUERY, 14'd1440);
      add_beat(KIND_QUERY, 14'd1441);
      add_beat(KIND_QUERY, 14'd2880);
      add_beat(KIND_QUERY, 14'd10079);
      add_beat(KIND_QUERY, 14'd11819);
      add_beat(KIND_QUERY, 14'd11820);
      add_beat(KIND_QUERY, 14'h3fff);
      add_beat(KIND_TICK, 14'h2aaa);
      add_beat(KIND_TICK, 14'h1555);
      add_beat(KIND_QUERY, 14'h2000);
      add_beat(KIND_QUERY, 14'h1555);

      for (n = 0; n < RANDOM_BEATS; n++) begin
         if ($urandom_range(0, 1) == 0) begin
            add_beat(KIND_TICK, 14'($urandom));
         end else begin
            add_beat(KIND_QUERY, random_lookback());
         end
      end

      // last part: no idling on either side, queries and ticks back to back
      calm_from = pending_beats.size();
      add_beat(KIND_QUERY, 14'd0);
      add_beat(KIND_QUERY, 14'd11819);
      for (k = 0; k < 40; k++) begin
         add_beat(KIND_QUERY, random_lookback());
         add_beat(KIND_TICK, 14'($urandom));
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (pending_beats.size() != 0 || req_chan.valid || expected_times.size() != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (expected_times.size() != 0) begin
         error_count++;
         $display("%0d expected responses never arrived", expected_times.size());
      end

      $display("checked %0d tick beats and %0d lookback queries, %0d beyond the lookback cap",
               ticks_checked, queries_checked, capped_queries);
      $display("clock ended at day %0d month %0d year %0d %0d:%0d:%0d, %0d errors",
               cur_day, cur_month, cur_year, cur_hour, cur_min, cur_sec, error_count);
      if (error_count == 0) begin
         $display("calendar_clock_with_lookback_core regression: pass");
      end else begin
         $display("calendar_clock_with_lookback_core regression: fail");
      end
      $finish;
   end

endmodule

FILE: files.f
src/cclb_pkg.sv
src/cclb_req_if.sv
src/cclb_rsp_if.sv
src/cclb_ctrl.sv
src/cclb_dp.sv
src/calendar_clock_with_lookback_core.sv
bench/testbench.sv
